// ===== src/slip_crc32_frame_receiver_assert.svh =====
// Assertion macros shared by the SLIP CRC-32 receiver RTL.
`ifndef SLIP_CRC32_FRAME_RECEIVER_ASSERT_SVH
`define SLIP_CRC32_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SRX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SRX_ASSERT(lbl, prop, msg)
`define SRX_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== src/srx_pkg.sv =====
// Package with types, constants and the CRC-32 byte step for the SLIP receiver.
`timescale 1ns / 1ps
package srx_pkg;

  localparam int unsigned BUFFER_BYTES  = 1024;
  localparam int unsigned PORTS         = 2;
  localparam int unsigned PORT_W        = 1;
  localparam int unsigned LIM_W         = 11;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned OUT_DEPTH     = 3;

  localparam logic [7:0] SLIP_END     = 8'o300;
  localparam logic [7:0] SLIP_ESC     = 8'o333;
  localparam logic [7:0] SLIP_ESC_END = 8'o334;
  localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Frame length limit bounds in use.
  localparam int unsigned LIM_HI_I = (BUFFER_BYTES < 1024) ? BUFFER_BYTES : 1024;
  localparam logic [LIM_W-1:0] LIM_HI    = LIM_W'(LIM_HI_I);
  localparam logic [LIM_W-1:0] LIM_LO    = LIM_W'(5);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1024);
  localparam logic [LIM_W-1:0] TRAILER_N = LIM_W'(TRAILER_BYTES);

  typedef enum logic [1:0] {
    ST_PAYLOAD,
    ST_GOOD,
    ST_BAD_CRC,
    ST_TOO_LONG
  } status_e;

  typedef struct packed {
    logic             esc;
    logic [31:0]      win;
    logic [LIM_W-1:0] cnt;
    logic [31:0]      crc;
    logic             ovf;
  } port_state_t;

  localparam int unsigned STATE_W = $bits(port_state_t);

  localparam port_state_t STATE_RST = '{
    esc: 1'b0, win: 32'h0, cnt: '0, crc: CRC_SEED, ovf: 1'b0
  };

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [7:0]        data;
    logic [9:0]        idx;
    logic              fend;
    status_e           status;
  } result_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/srx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module srx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                  wdata_i,
  input  logic                              re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/srx_update.sv =====
// Per-byte SLIP decode, delay line, CRC step and frame status for one port state.
`timescale 1ns / 1ps
module srx_update (
  input  logic [srx_pkg::LIM_W-1:0]  lim_i,
  input  logic [srx_pkg::PORT_W-1:0] port_i,
  input  logic [7:0]                 byte_i,
  input  srx_pkg::port_state_t       st_i,
  output srx_pkg::port_state_t       st_o,
  output logic                       res_vld_o,
  output srx_pkg::result_t           res_o
);

  logic                      take;
  logic [7:0]                dec;
  logic [srx_pkg::LIM_W-1:0] cnt_m4;
  logic [31:0]               rx_crc;

  assign cnt_m4 = st_i.cnt - srx_pkg::TRAILER_N;
  // The trailer arrives least significant byte first.
  assign rx_crc = {st_i.win[7:0], st_i.win[15:8], st_i.win[23:16], st_i.win[31:24]};

  always_comb begin
    st_o        = st_i;
    res_vld_o   = 1'b0;
    res_o.port  = port_i;
    res_o.data  = 8'h00;
    res_o.idx   = cnt_m4[9:0];
    res_o.fend  = 1'b0;
    res_o.status = srx_pkg::ST_PAYLOAD;
    take        = 1'b0;
    dec         = byte_i;

    if (st_i.esc) begin
      st_o.esc = 1'b0;
      take     = 1'b1;
      if (byte_i == srx_pkg::SLIP_ESC_END) begin
        dec = srx_pkg::SLIP_END;
      end else if (byte_i == srx_pkg::SLIP_ESC_ESC) begin
        dec = srx_pkg::SLIP_ESC;
      end
    end else if (byte_i == srx_pkg::SLIP_ESC) begin
      st_o.esc = 1'b1;
    end else if (byte_i == srx_pkg::SLIP_END) begin
      if (st_i.cnt > srx_pkg::TRAILER_N) begin
        res_vld_o  = 1'b1;
        res_o.fend = 1'b1;
        if (st_i.ovf) begin
          res_o.status = srx_pkg::ST_TOO_LONG;
        end else if ((st_i.crc ^ srx_pkg::CRC_SEED) == rx_crc) begin
          res_o.status = srx_pkg::ST_GOOD;
        end else begin
          res_o.status = srx_pkg::ST_BAD_CRC;
        end
      end
      st_o = srx_pkg::STATE_RST;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (st_i.cnt >= lim_i) begin
        st_o.ovf = 1'b1;
      end else begin
        // Once the delay line is full, the byte falling out is payload.
        if (st_i.cnt >= srx_pkg::TRAILER_N) begin
          st_o.crc   = srx_pkg::crc32_byte(st_i.crc, st_i.win[31:24]);
          res_vld_o  = 1'b1;
          res_o.data = st_i.win[31:24];
        end
        st_o.win = {st_i.win[23:0], dec};
        st_o.cnt = st_i.cnt + srx_pkg::LIM_W'(1);
      end
    end
  end

endmodule

// ===== src/srx_out_fifo.sv =====
// Three-word result queue that decouples the update stage from the output.
`timescale 1ns / 1ps
module srx_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srx_pkg::result_t din_i,
  input  logic             pop_i,
  output srx_pkg::result_t dout_o,
  output logic             valid_o,
  output logic [1:0]       count_o
);

  srx_pkg::result_t mem_q [srx_pkg::OUT_DEPTH];
  logic [1:0] wr_q, wr_d, rd_q, rd_d, cnt_q, cnt_d;
  logic       do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == 2'(srx_pkg::OUT_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
    end
    if (do_pop) begin
      rd_d = (rd_q == 2'(srx_pkg::OUT_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  assign dout_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != 2'd0);
  assign count_o = cnt_q;

endmodule

// ===== src/slip_crc32_frame_receiver.sv =====
// Top level of the two-port SLIP frame receiver with CRC-32 check.
//
//  Channel   Direction  Signals                         Contents
//  s_axis    in         tvalid/tready/tdata/tuser       line byte and its port
//  m_axis    out        tvalid/tready/tdata/tuser/tlast payload bytes and status
//  cfg       in         valid/ready/data                max_frame_bytes
//
// An item is accepted in every cycle that tready is high; the per-port state RAM is read
// at accept and written in the following cycle, and each result is then queued for output.
// Back-to-back bytes on the same port take the just-written state from a bypass
// register instead of the RAM.
// A three-word output queue lets input continue while results wait; input
// stalls only when the queue and the update stage together hold three words.
// Reset is asynchronous; port state reads as its reset value until first written.
`timescale 1ns / 1ps
`include "slip_crc32_frame_receiver_assert.svh"
module slip_crc32_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] port
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] payload_byte, [17:8] payload_index
  output logic [2:0]  m_axis_tuser_o,   // [0] out_port, [2:1] status
  output logic        m_axis_tlast_o,   // frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  logic                        accept, in_ok;
  logic                        s1_vld_q, s1_vld_d;
  logic [srx_pkg::PORT_W-1:0]  s1_port_q;
  logic [7:0]                  s1_byte_q;
  logic [srx_pkg::PORTS-1:0]   vld_q;
  logic                        byp_vld_q;
  logic [srx_pkg::PORT_W-1:0]  byp_port_q;
  srx_pkg::port_state_t        byp_q;
  logic [srx_pkg::LIM_W-1:0]   lim_q, lim_d;
  logic [srx_pkg::STATE_W-1:0] rd_data;
  srx_pkg::port_state_t        cur_st, new_st;
  logic                        res_vld;
  srx_pkg::result_t            res, out_res;
  logic [1:0]                  q_cnt;
  logic                        out_vld, pop;

  assign in_ok  = (32'(s_axis_tuser_i) < srx_pkg::PORTS);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_vld_d = accept && in_ok;
  assign s_axis_tready_o = ({1'b0, q_cnt} + {2'b00, s1_vld_q}) <= 3'd2;

  // Configuration: the limit is stored already clamped.
  assign cfg_ready_o = 1'b1;
  always_comb begin
    lim_d = lim_q;
    if (cfg_valid_i) begin
      if (cfg_data_i > srx_pkg::LIM_HI) begin
        lim_d = srx_pkg::LIM_HI;
      end else if (cfg_data_i < srx_pkg::LIM_LO) begin
        lim_d = srx_pkg::LIM_LO;
      end else begin
        lim_d = cfg_data_i;
      end
    end
  end

  srx_ram #(
    .WIDTH(srx_pkg::STATE_W),
    .DEPTH(srx_pkg::PORTS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_port_q),
    .wdata_i(new_st),
    .re_i   (accept),
    .raddr_i(s_axis_tuser_i),
    .rdata_o(rd_data)
  );

  // The write of the previous cycle is not yet visible in the read data.
  always_comb begin
    if (byp_vld_q && (byp_port_q == s1_port_q)) begin
      cur_st = byp_q;
    end else if (vld_q[s1_port_q]) begin
      cur_st = srx_pkg::port_state_t'(rd_data);
    end else begin
      cur_st = srx_pkg::STATE_RST;
    end
  end

  srx_update u_update (
    .lim_i    (lim_q),
    .port_i   (s1_port_q),
    .byte_i   (s1_byte_q),
    .st_i     (cur_st),
    .st_o     (new_st),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  assign pop = m_axis_tready_i;

  srx_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_vld_q && res_vld),
    .din_i  (res),
    .pop_i  (pop),
    .dout_o (out_res),
    .valid_o(out_vld),
    .count_o(q_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      vld_q     <= '0;
      lim_q     <= srx_pkg::LIM_RESET;
    end else begin
      s1_vld_q  <= s1_vld_d;
      byp_vld_q <= s1_vld_q;
      lim_q     <= lim_d;
      if (s1_vld_q) begin
        vld_q[s1_port_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_port_q <= s_axis_tuser_i;
      s1_byte_q <= s_axis_tdata_i;
    end
    if (s1_vld_q) begin
      byp_q      <= new_st;
      byp_port_q <= s1_port_q;
    end
  end

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {6'b000000, out_res.idx, out_res.data};
  assign m_axis_tuser_o  = {out_res.status, out_res.port};
  assign m_axis_tlast_o  = out_res.fend;

  `SRX_ASSERT(a_queue_no_overrun, !(s1_vld_q && res_vld && (q_cnt == 2'd3) && !pop), "output queue overrun")
  `SRX_ASSERT_IMP(a_s1_from_accept, s1_vld_q, $past(accept), "update stage valid without an accepted word")
  `SRX_ASSERT_IMP(a_end_has_status, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o[2:1] != srx_pkg::ST_PAYLOAD, "frame end word without status")
  `SRX_ASSERT_IMP(a_count_in_limit, s1_vld_q && (cur_st.cnt <= lim_q), new_st.cnt <= lim_q, "count beyond limit")

endmodule
